### hdl/u8d_pkg.sv
`default_nettype none
package u8d_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] ReplChar = 21'h00FFFD;

  // lead and continuation byte classes
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  // one queued job: a run of replacements, then an optional tail result
  typedef struct packed {
    logic [1:0]         rep_cnt;
    logic               has_tail;
    logic [CpWidth-1:0] tail_cp;
    logic               tail_repl;
  } job_t;

endpackage
`default_nettype wire

### hdl/utf8_byte_stream_decoder.sv
`default_nettype none
// channel   | dir | payload                                   | handshake
// s_axis    | in  | tdata[7:0] data_byte, tlast end_of_text   | tvalid/tready
// m_axis    | out | tdata[20:0] code_point, tuser             | tvalid/tready
//           |     | is_replacement, tlast last_of_run         |
//
// one input word is taken per cycle while the job queue has room
// each result word leaves the output register on its own handshake, so a byte that
// causes n results keeps the emitter busy for n result words (n at most 4)
// a byte that completes a code point and no error is written to the job queue
// when it is taken, then loaded into the output register and shown on m_axis
// an end of text with nothing pending causes no word
// reset is asynchronous, active low, and returns the decoder to idle
// m_axis stalls back up through the queue to s_axis_tready_o
module utf8_byte_stream_decoder
  import u8d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // end_of_text
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [20:0] code_point, [23:21] zero
  output logic             m_axis_tuser_o,   // is_replacement
  output logic             m_axis_tlast_o    // last_of_run
);

  // front to queue
  logic  take;
  logic  push;
  job_t  push_job;

  // queue to back
  job_t  head_job;
  logic  q_full;
  logic  q_empty;
  logic  pop;

  logic [CpWidth-1:0] code_point;

  // the front keeps the decode state and takes a word whenever the queue
  // has a free slot
  assign s_axis_tready_o = !q_full;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  u8d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .data_byte_i   (s_axis_tdata_i),
    .end_of_text_i (s_axis_tlast_i),
    .push_o        (push),
    .job_o         (push_job)
  );

  // short job queue decouples byte intake from result emission
  u8d_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // the back expands each job into its replacement run and tail result
  u8d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (head_job),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .code_point_o     (code_point),
    .is_replacement_o (m_axis_tuser_o),
    .last_of_run_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(24-CpWidth){1'b0}}, code_point};

endmodule
`default_nettype wire

### hdl/u8d_front.sv
`default_nettype none
module u8d_front
  import u8d_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_text_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [1:0]         bytes_expected_q, bytes_expected_d;
  logic [1:0]         bytes_received_q, bytes_received_d;
  logic [CpWidth-1:0] partial_value_q, partial_value_d;

  logic               is_cont;
  logic [1:0]         rcv_inc;
  logic [CpWidth-1:0] pv_shift;
  logic               lead_tail, lead_repl;
  logic [1:0]         lead_exp;
  logic [CpWidth-1:0] lead_pv, lead_cp;
  logic [1:0]         flush_cnt;

  assign is_cont   = (data_byte_i & ContMask) == ContCode;
  assign rcv_inc   = bytes_received_q + 2'd1;
  assign pv_shift  = {partial_value_q[CpWidth-7:0], data_byte_i[5:0]};
  assign flush_cnt = bytes_received_q + 2'd1;

  // lead byte classification
  always_comb begin
    lead_tail = 1'b0;
    lead_repl = 1'b0;
    lead_exp  = 2'd0;
    lead_pv   = '0;
    lead_cp   = ReplChar;
    if (data_byte_i[7] == 1'b0) begin
      lead_tail = 1'b1;
      lead_cp   = {{(CpWidth-8){1'b0}}, data_byte_i};
    end else if ((data_byte_i & Lead2Mask) == Lead2Code) begin
      lead_exp = 2'd1;
      lead_pv  = {{(CpWidth-5){1'b0}}, data_byte_i[4:0]};
    end else if ((data_byte_i & Lead3Mask) == Lead3Code) begin
      lead_exp = 2'd2;
      lead_pv  = {{(CpWidth-4){1'b0}}, data_byte_i[3:0]};
    end else if ((data_byte_i & Lead4Mask) == Lead4Code) begin
      lead_exp = 2'd3;
      lead_pv  = {{(CpWidth-3){1'b0}}, data_byte_i[2:0]};
    end else begin
      lead_tail = 1'b1;
      lead_repl = 1'b1;
    end
  end

  always_comb begin
    bytes_expected_d = bytes_expected_q;
    bytes_received_d = bytes_received_q;
    partial_value_d  = partial_value_q;
    job_o            = '0;
    job_o.tail_cp    = ReplChar;
    if (end_of_text_i) begin
      job_o.rep_cnt    = (bytes_expected_q != 2'd0) ? flush_cnt : 2'd0;
      bytes_expected_d = 2'd0;
      bytes_received_d = 2'd0;
    end else if (bytes_expected_q == 2'd0) begin
      job_o.has_tail   = lead_tail;
      job_o.tail_cp    = lead_cp;
      job_o.tail_repl  = lead_repl;
      bytes_expected_d = lead_exp;
      bytes_received_d = 2'd0;
      partial_value_d  = lead_pv;
    end else if (is_cont) begin
      if (rcv_inc >= bytes_expected_q) begin
        job_o.has_tail   = 1'b1;
        job_o.tail_cp    = pv_shift;
        bytes_expected_d = 2'd0;
        bytes_received_d = 2'd0;
      end else begin
        bytes_received_d = rcv_inc;
        partial_value_d  = pv_shift;
      end
    end else begin
      // abandoned sequence, then the byte starts over as a lead
      job_o.rep_cnt    = flush_cnt;
      job_o.has_tail   = lead_tail;
      job_o.tail_cp    = lead_cp;
      job_o.tail_repl  = lead_repl;
      bytes_expected_d = lead_exp;
      bytes_received_d = 2'd0;
      partial_value_d  = lead_pv;
    end
  end

  assign push_o = take_i && (job_o.has_tail || (job_o.rep_cnt != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_expected_q <= 2'd0;
      bytes_received_q <= 2'd0;
      partial_value_q  <= '0;
    end else if (take_i) begin
      bytes_expected_q <= bytes_expected_d;
      bytes_received_q <= bytes_received_d;
      partial_value_q  <= partial_value_d;
    end
  end

  a_rcv_below_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_expected_q == 2'd0) || (bytes_received_q < bytes_expected_q))
    else $error("received count reached expected count");

endmodule
`default_nettype wire

### hdl/u8d_fifo.sv
`default_nettype none
module u8d_fifo
  import u8d_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t wdata_i,
  input  wire logic pop_i,
  output job_t      rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

### hdl/u8d_back.sv
`default_nettype none
module u8d_back
  import u8d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire job_t        job_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [CpWidth-1:0] code_point_o,
  output logic             is_replacement_o,
  output logic             last_of_run_o
);

  logic [1:0]         idx_q, idx_d;
  logic               valid_q, valid_d;
  logic [CpWidth-1:0] cp_q, cp_d;
  logic               repl_q, repl_d;
  logic               last_q, last_d;
  logic               load;
  logic [2:0]         total;
  logic               is_last;

  assign load    = (!valid_q || out_ready_i) && !empty_i;
  assign total   = {1'b0, job_i.rep_cnt} + {2'b00, job_i.has_tail};
  assign is_last = ({1'b0, idx_q} + 3'd1) == total;
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !out_ready_i;
    cp_d    = cp_q;
    repl_d  = repl_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      last_d  = is_last;
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
      if (idx_q < job_i.rep_cnt) begin
        cp_d   = ReplChar;
        repl_d = 1'b1;
      end else begin
        cp_d   = job_i.tail_cp;
        repl_d = job_i.tail_repl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    repl_q <= repl_d;
    last_q <= last_d;
  end

  assign out_valid_o      = valid_q;
  assign code_point_o     = cp_q;
  assign is_replacement_o = repl_q;
  assign last_of_run_o    = last_q;

  a_pop_gives_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_o && last_of_run_o))
    else $error("job retired without a closing result");

  a_idx_zero_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 2'd0))
    else $error("result index not cleared at job end");

endmodule
`default_nettype wire

### dv/tb_utf8_byte_stream_decoder.sv
`default_nettype none
module tb_utf8_byte_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  // one code point word as it leaves m_axis
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               is_replacement;
    logic               last_of_run;
  } cp_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic        m_user;
  logic        m_last;

  // stimulus knobs; rx_gaps and hold_cycles are shared with the receiver process
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_cycles = 0;

  // decoder state as predicted
  logic [1:0]         seq_need = 2'd0;
  logic [1:0]         seq_got = 2'd0;
  logic [CpWidth-1:0] seq_acc = '0;
  cp_word_t           run_q[$];
  cp_word_t           cp_expect_q[$];

  int errors = 0;
  int words_sent = 0;
  int eot_sent = 0;
  int cps_checked = 0;
  int repl_seen = 0;

  utf8_byte_stream_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always #5 clk_i = ~clk_i;

  function automatic void add_cp(input logic [CpWidth-1:0] cp, input logic repl);
    cp_word_t w;
    w.code_point     = cp;
    w.is_replacement = repl;
    w.last_of_run    = 1'b0;
    run_q.push_back(w);
  endfunction

  // lead plus every continuation taken so far becomes a replacement
  function automatic void abandon_seq();
    if (seq_need != 2'd0) begin
      add_cp(ReplChar, 1'b1);
      for (int i = 0; i < seq_got; i++) add_cp(ReplChar, 1'b1);
    end
    seq_need = 2'd0;
    seq_got  = 2'd0;
    seq_acc  = '0;
  endfunction

  function automatic void open_lead(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      add_cp(CpWidth'(b), 1'b0);
    end else if ((b & Lead2Mask) == Lead2Code) begin
      seq_acc  = CpWidth'(b & ~Lead2Mask);
      seq_need = 2'd1;
      seq_got  = 2'd0;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      seq_acc  = CpWidth'(b & ~Lead3Mask);
      seq_need = 2'd2;
      seq_got  = 2'd0;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      seq_acc  = CpWidth'(b & ~Lead4Mask);
      seq_need = 2'd3;
      seq_got  = 2'd0;
    end else begin
      add_cp(ReplChar, 1'b1);
    end
  endfunction

  function automatic void predict_code_points(input logic [7:0] b, input logic eot);
    run_q.delete();
    if (eot) begin
      abandon_seq();
    end else if (seq_need == 2'd0) begin
      open_lead(b);
    end else if ((b & ContMask) == ContCode) begin
      seq_acc = {seq_acc[CpWidth-7:0], b[5:0]};
      seq_got = seq_got + 2'd1;
      if (seq_got >= seq_need) begin
        add_cp(seq_acc, 1'b0);
        seq_need = 2'd0;
        seq_got  = 2'd0;
        seq_acc  = '0;
      end
    end else begin
      // bad continuation: flush, then rescan this byte as a lead
      abandon_seq();
      open_lead(b);
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    foreach (run_q[i]) cp_expect_q.push_back(run_q[i]);
  endfunction

  // one input word; valid stays up after acceptance so back-to-back words need no gap
  task automatic send_word(input logic [7:0] b, input logic eot);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= eot;
    do @(posedge clk_i); while (!s_ready);
    predict_code_points(b, eot);
    words_sent++;
    if (eot) eot_sent++;
  endtask

  task automatic send_eot();
    send_word(8'($urandom), 1'b1);
  endtask

  // lead of a len-byte sequence with random payload, then n_cont continuations
  task automatic send_sequence(input int len, input int n_cont);
    logic [7:0] r;
    logic [7:0] lead;
    r = 8'($urandom);
    case (len)
      1: lead = {1'b0, r[6:0]};
      2: lead = {3'b110, r[4:0]};
      3: lead = {4'b1110, r[3:0]};
      default: lead = {5'b11110, r[2:0]};
    endcase
    send_word(lead, 1'b0);
    for (int i = 0; i < n_cont; i++) begin
      r = 8'($urandom);
      send_word({2'b10, r[5:0]}, 1'b0);
    end
  endtask

  task automatic send_non_cont();
    logic [7:0] r;
    do r = 8'($urandom); while (r[7:6] == 2'b10);
    send_word(r, 1'b0);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (cp_expect_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic test_directed();
    send_word(8'h00, 1'b0);           // zero byte is U+0000
    send_word(8'h7F, 1'b0);
    send_word(8'hC2, 1'b0);           // two-byte U+00A9
    send_word(8'hA9, 1'b0);
    send_word(8'hE2, 1'b0);           // three-byte U+20AC
    send_word(8'h82, 1'b0);
    send_word(8'hAC, 1'b0);
    send_word(8'hF7, 1'b0);           // four-byte, all ones, U+1FFFFF
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hC0, 1'b0);           // overlong nul passes through
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);           // stray continuation
    send_word(8'hFF, 1'b0);           // 11111xxx lead
    send_word(8'hF0, 1'b0);           // bad continuation after two: four words
    send_word(8'h9F, 1'b0);
    send_word(8'h98, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'hE2, 1'b0);           // bad continuation that is itself a lead
    send_word(8'hC3, 1'b0);
    send_word(8'hA9, 1'b0);
    send_word(8'hF0, 1'b0);           // end of text with a sequence pending
    send_word(8'h90, 1'b0);
    send_word(8'hFF, 1'b1);
    send_eot();                       // end of text while idle: nothing
    wait_drained();
  endtask

  // receiver holds off long enough for the queue to fill and stall s_axis
  task automatic test_output_stall();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_cycles = 120;
    for (int i = 0; i < 12; i++) begin
      send_word(8'hF0, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hFF, 1'b0);
    end
    wait_drained();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // sender goes quiet until every result is out, then resumes mid-text
  task automatic test_pause_for_drain();
    for (int i = 0; i < 3; i++) begin
      send_sequence(4, 2);
      send_non_cont();
      wait_drained();
      send_sequence(3, 2);
      send_sequence(2, 1);
    end
    wait_drained();
  endtask

  task automatic test_random_text(input int n_items);
    int first;
    int kind;
    int len;
    first = words_sent;
    while (words_sent - first < n_items) begin
      if ($urandom_range(0, 15) == 0) begin
        tx_gaps = ($urandom_range(0, 2) != 0);
        rx_gaps = ($urandom_range(0, 2) != 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = $urandom_range(1, 4);
        send_sequence(len, len - 1);
      end else if (kind < 84) begin
        // truncated sequence, broken by a foreign byte or end of text
        len = $urandom_range(2, 4);
        send_sequence(len, $urandom_range(0, len - 2));
        if ($urandom_range(0, 3) == 0) send_eot();
        else send_non_cont();
      end else if (kind < 94) begin
        send_word(8'($urandom), 1'b0);
      end else begin
        send_eot();
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    wait_drained();
  endtask

  // receiver: random stall before each word, plus a one-off long hold
  initial begin
    int stall;
    @(negedge clk_i);
    forever begin
      stall = hold_cycles + (rx_gaps ? $urandom_range(0, 3) : 0);
      hold_cycles = 0;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
      @(negedge clk_i);
    end
  end

  // checker: each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    cp_word_t got_w;
    cp_word_t exp_w;
    if (rst_ni && m_valid && m_ready) begin
      got_w.code_point     = m_data[CpWidth-1:0];
      got_w.is_replacement = m_user;
      got_w.last_of_run    = m_last;
      if (cp_expect_q.size() == 0) begin
        $error("unexpected word: code_point %h", got_w.code_point);
        errors++;
      end else begin
        exp_w = cp_expect_q.pop_front();
        if (got_w.code_point !== exp_w.code_point) begin
          $error("code_point: expected %h, got %h", exp_w.code_point, got_w.code_point);
          errors++;
        end
        if (got_w.is_replacement !== exp_w.is_replacement) begin
          $error("is_replacement: expected %b, got %b",
                 exp_w.is_replacement, got_w.is_replacement);
          errors++;
        end
        if (got_w.last_of_run !== exp_w.last_of_run) begin
          $error("last_of_run: expected %b, got %b", exp_w.last_of_run, got_w.last_of_run);
          errors++;
        end
        cps_checked++;
        if (exp_w.is_replacement) repl_seen++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL utf8_byte_stream_decoder");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_output_stall();
    test_pause_for_drain();
    test_random_text(100);

    // tail: let any stray word show up before the final verdict
    repeat (16) @(posedge clk_i);
    if (cp_expect_q.size() != 0) begin
      $error("%0d expected code points never arrived", cp_expect_q.size());
      errors++;
    end
    $display("run covered %0d input words (%0d end of text) and %0d code points,",
             words_sent, eot_sent, cps_checked);
    $display("%0d of them replacements, with stalls on both sides", repl_seen);
    if (errors == 0) begin
      $display("PASS utf8_byte_stream_decoder");
    end else begin
      $display("FAIL utf8_byte_stream_decoder");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
hdl/u8d_pkg.sv
hdl/u8d_front.sv
hdl/u8d_fifo.sv
hdl/u8d_back.sv
hdl/utf8_byte_stream_decoder.sv
dv/tb_utf8_byte_stream_decoder.sv
